>>> rtl/part_pkg.sv
// Package for the port access rule table: command codes, rule record type,
// field widths and the default table depth. No dependencies.
`default_nettype none
package part_pkg;

  localparam int unsigned DefRuleSlots = 32;
  localparam int unsigned PortW        = 64;
  localparam int unsigned TgtW         = 16;
  localparam int unsigned CodeW        = 3;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [PortW-1:0] port_high;
    logic [PortW-1:0] port_low;
    logic [TgtW-1:0]  target;
    logic [CodeW-1:0] code;
  } rule_t;

  localparam int unsigned RuleW = $bits(rule_t);

  // memory access request from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

>>> rtl/port_access_rule_table.sv
// Top level of the port access rule table: command sequencer around the
// rule memory. Depends on part_pkg and part_rule_mem.
//
// Rules live in one memory with registered read data and are always packed
// into slots 0..count-1 in table order. A command is taken when start is
// high and busy is low. Each command walks the table one slot per cycle:
// a read is issued every cycle and the slot read the cycle before is
// compared, and written back or moved, in the same cycle. A check or an
// update stops early on an exact match. A finishing state follows the
// walk, and busy stays high from the accepting edge until the command is
// done. Clear copies kept rules down over removed ones inside the same
// walk. Remove does the same for the rules behind the match. An add that
// inserts at the head (all-zero port name) then shifts every rule up one
// slot, top first, and then writes the head. The result strobes out_valid
// for one cycle, the first cycle with busy low. The receiver cannot hold
// it off. With start held high, a new item is taken in that cycle too;
// no item is taken while busy is high.
`default_nettype none
module port_access_rule_table
  import part_pkg::*;
#(
  parameter int unsigned RULE_SLOTS = DefRuleSlots,
  localparam int unsigned AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
  localparam int unsigned CW = $clog2(RULE_SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_command,
  input  wire logic [63:0]      in_port_name_high,
  input  wire logic [63:0]      in_port_name_low,
  input  wire logic [15:0]      in_target_number,
  input  wire logic [2:0]       in_rule_code,
  input  wire logic             in_every_target,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_allow_code,
  output logic                  out_valid,
  output logic [2:0]            out_verdict,
  output logic                  out_status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,   // read slot rd_r, compare slot cmp_r
    ST_FIN,    // settle count, tail write, pick verdict
    ST_SHIFT,  // head insert: move slot cmp_r up to cmp_r+1, walking down
    ST_HEAD    // head insert: write the new rule to slot 0
  } state_t;

  state_t           state_r;
  logic [2:0]       allow_r;
  logic [CW-1:0]    count_r;
  cmd_t             cmd_r;
  rule_t            req_r;
  logic             every_r;

  // walk pointers
  logic [CW-1:0]    rd_r;        // next slot to read (shift: one above it)
  logic             pend_r;      // read data valid for slot cmp_r
  logic [CW-1:0]    cmp_r;
  logic [CW-1:0]    wr_r;        // clear: where the next kept rule goes
  logic             found_r;
  logic [CodeW-1:0] verdict_r;
  logic [CodeW-1:0] cat_r [4];

  // result registers
  logic             valid_r;
  logic [2:0]       res_verdict_r;
  logic             res_status_r;

  mem_ctl_t         mctl;
  logic [AW-1:0]    mwa, mra;
  rule_t            mwd, mrd;

  part_rule_mem #(.RULE_SLOTS(RULE_SLOTS)) u_mem (
    .clk(clk), .ctl(mctl), .wr_addr(mwa), .wr_data(mwd),
    .rd_addr(mra), .rd_data(mrd)
  );

  // compare the slot just read against the request
  logic same_port, same_tgt, exact, del_hit;
  always_comb begin
    same_port = (mrd.port_high == req_r.port_high) && (mrd.port_low == req_r.port_low);
    same_tgt  = (mrd.target == req_r.target);
    exact     = same_port && same_tgt;
    del_hit   = every_r || same_tgt;
  end

  // walk control and end-of-command decisions
  logic             port_zero, full, head_ins, stop_hit, issue;
  logic [CW-1:0]    rd_dec, cmp_dec, cmp_inc;
  logic [CodeW-1:0] cat_pick;
  logic             done_nxt;
  logic [2:0]       verdict_nxt;
  logic             status_nxt;
  always_comb begin
    port_zero = (req_r.port_high == '0) && (req_r.port_low == '0);
    full      = (count_r >= CW'(RULE_SLOTS));
    head_ins  = (cmd_r == CMD_ADD) && !found_r && !full && port_zero;
    stop_hit  = pend_r && exact && (cmd_r == CMD_ADD || cmd_r == CMD_CHECK);
    rd_dec    = rd_r - CW'(1);
    cmp_dec   = cmp_r - CW'(1);
    cmp_inc   = cmp_r + CW'(1);
    issue     = 1'b0;
    if (state_r == ST_SCAN) begin
      issue = (rd_r < count_r) && !stop_hit;
    end else if (state_r == ST_SHIFT) begin
      issue = (rd_r != '0);
    end
    if (cat_r[0] != '0)      cat_pick = cat_r[0];
    else if (cat_r[1] != '0) cat_pick = cat_r[1];
    else if (cat_r[2] != '0) cat_pick = cat_r[2];
    else if (cat_r[3] != '0) cat_pick = cat_r[3];
    else                     cat_pick = allow_r;
    done_nxt    = ((state_r == ST_FIN) && !head_ins) || (state_r == ST_HEAD);
    status_nxt  = (cmd_r == CMD_ADD) && !found_r && full;
    verdict_nxt = '0;
    if (cmd_r == CMD_CHECK) verdict_nxt = found_r ? verdict_r : cat_pick;
  end

  // memory port control
  always_comb begin
    mctl       = '0;
    mctl.rd_en = issue;
    mra        = rd_r[AW-1:0];
    mwa        = cmp_r[AW-1:0];
    mwd        = mrd;
    case (state_r)
      ST_SCAN: begin
        if (pend_r) begin
          case (cmd_r)
            CMD_ADD: begin
              // update in place
              if (exact) begin
                mctl.wr_en = 1'b1;
                mwd = req_r;
              end
            end
            CMD_REMOVE: begin
              // after the hit, compact later rules down by one
              if (found_r) begin
                mctl.wr_en = 1'b1;
                mwa = cmp_dec[AW-1:0];
              end
            end
            CMD_CLEAR: begin
              if (!del_hit && wr_r != cmp_r) begin
                mctl.wr_en = 1'b1;
                mwa = wr_r[AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIN: begin
        // tail insert
        if (cmd_r == CMD_ADD && !found_r && !full && !port_zero) begin
          mctl.wr_en = 1'b1;
          mwa = count_r[AW-1:0];
          mwd = req_r;
        end
      end
      ST_SHIFT: begin
        mra = rd_dec[AW-1:0];
        if (pend_r) begin
          mctl.wr_en = 1'b1;
          mwa = cmp_inc[AW-1:0];
        end
      end
      ST_HEAD: begin
        mctl.wr_en = 1'b1;
        mwa = '0;
        mwd = req_r;
      end
      default: ;
    endcase
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = valid_r;
  assign out_verdict = res_verdict_r;
  assign out_status  = res_status_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      allow_r       <= 3'd1;
      count_r       <= '0;
      pend_r        <= 1'b0;
      valid_r       <= 1'b0;
      res_verdict_r <= '0;
      res_status_r  <= 1'b0;
    end else begin
      if (cfg_we) allow_r <= cfg_allow_code;
      valid_r <= done_nxt;
      if (done_nxt) begin
        res_verdict_r <= verdict_nxt;
        res_status_r  <= status_nxt;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            cmd_r     <= cmd_t'(in_command);
            req_r     <= '{in_port_name_high, in_port_name_low, in_target_number,
                           in_rule_code};
            every_r   <= in_every_target;
            rd_r      <= '0;
            wr_r      <= '0;
            pend_r    <= 1'b0;
            found_r   <= 1'b0;
            verdict_r <= '0;
            for (int k = 0; k < 4; k++) cat_r[k] <= '0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_r <= issue;
          if (issue) begin
            cmp_r <= rd_r;
            rd_r  <= rd_r + CW'(1);
          end
          if (pend_r) begin
            case (cmd_r)
              CMD_ADD, CMD_REMOVE: begin
                if (exact) found_r <= 1'b1;
              end
              CMD_CLEAR: begin
                if (!del_hit) wr_r <= wr_r + CW'(1);
              end
              default: begin // check
                if (exact) begin
                  found_r   <= 1'b1;
                  verdict_r <= mrd.code;
                end
                else if (same_port && mrd.target == '0) cat_r[0] <= mrd.code;
                else if (same_tgt)                      cat_r[1] <= mrd.code;
                else if (mrd.port_low == '0)            cat_r[2] <= mrd.code;
                else if (mrd.target == '0)              cat_r[3] <= mrd.code;
              end
            endcase
          end
          // nothing issued: the last compare happens this cycle
          if (!issue) state_r <= ST_FIN;
        end
        ST_FIN: begin
          rd_r    <= count_r;
          state_r <= head_ins ? ST_SHIFT : ST_IDLE;
          case (cmd_r)
            CMD_ADD: begin
              if (!found_r && !full && !port_zero) count_r <= count_r + CW'(1);
            end
            CMD_REMOVE: begin
              if (found_r) count_r <= count_r - CW'(1);
            end
            CMD_CLEAR: begin
              count_r <= wr_r;
            end
            default: ;
          endcase
        end
        ST_SHIFT: begin
          pend_r <= issue;
          if (issue) begin
            cmp_r <= rd_dec;
            rd_r  <= rd_dec;
          end
          if (!issue) state_r <= ST_HEAD;
        end
        default: begin // ST_HEAD
          count_r <= count_r + CW'(1);
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RULE_SLOTS)) else $error("rule count overflow");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (cmd_r == CMD_ADD && count_r == CW'(RULE_SLOTS)))
    else $error("full status with free slots");

endmodule
`default_nettype wire

>>> rtl/part_rule_mem.sv
// Rule storage: one synchronous memory, one write and one read port,
// registered read data. Depends on part_pkg.
`default_nettype none
module part_rule_mem
  import part_pkg::*;
#(
  parameter int unsigned RULE_SLOTS = DefRuleSlots,
  localparam int unsigned AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire mem_ctl_t      ctl,
  input  wire logic [AW-1:0] wr_addr,
  input  wire rule_t         wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output rule_t              rd_data
);

  rule_t mem [RULE_SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered, updated only when rd_en is high
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> test/tb_port_access_rule_table.sv
// Testbench for port_access_rule_table: drives add, remove, clear and check
// items, predicts each verdict and status, and compares. Depends on part_pkg.
`default_nettype none
module tb_port_access_rule_table
  import part_pkg::*;
;

  localparam int Slots = 32;
  localparam int CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = 2'd0;
  logic [63:0] in_port_name_high = '0;
  logic [63:0] in_port_name_low = '0;
  logic [15:0] in_target_number = '0;
  logic [2:0]  in_rule_code = '0;
  logic        in_every_target = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_allow_code = 3'd1;
  logic        out_valid;
  logic [2:0]  out_verdict;
  logic        out_status;

  port_access_rule_table u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_port_name_high(in_port_name_high),
    .in_port_name_low(in_port_name_low), .in_target_number(in_target_number),
    .in_rule_code(in_rule_code), .in_every_target(in_every_target),
    .cfg_we(cfg_we), .cfg_allow_code(cfg_allow_code),
    .out_valid(out_valid), .out_verdict(out_verdict), .out_status(out_status)
  );

  always #1 clk = ~clk;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] tgt;
    logic [2:0]  code;
    logic        every;
  } item_t;

  typedef struct {
    logic [2:0] verdict;
    logic       status;
  } answer_t;

  // table model
  rule_t      rules[$];
  logic [2:0] allow_now = 3'd1;
  answer_t    pending_answers[$];
  int         errors = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // apply one item to the table model, return the expected answer
  function automatic answer_t rule_table_apply(input item_t it);
    answer_t a;
    logic [2:0] cat[4];
    logic same_port;
    bit hit;
    rule_t r;
    a.verdict = 3'd0;
    a.status = 1'b0;
    hit = 1'b0;
    case (it.cmd)
      CMD_ADD: begin
        foreach (rules[i]) begin
          if (!hit && rules[i].port_high == it.hi && rules[i].port_low == it.lo &&
              rules[i].target == it.tgt) begin
            rules[i].code = it.code;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          r = '{port_high: it.hi, port_low: it.lo, target: it.tgt, code: it.code};
          if (rules.size() >= Slots) a.status = 1'b1;
          else if (it.hi == 0 && it.lo == 0) rules.push_front(r);
          else rules.push_back(r);
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < rules.size(); i++) begin
          if (rules[i].port_high == it.hi && rules[i].port_low == it.lo &&
              rules[i].target == it.tgt) begin
            rules.delete(i);
            break;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = rules.size() - 1; i >= 0; i--)
          if (it.every || rules[i].target == it.tgt) rules.delete(i);
      end
      default: begin
        cat = '{3'd0, 3'd0, 3'd0, 3'd0};
        foreach (rules[i]) begin
          if (!hit) begin
            same_port = rules[i].port_high == it.hi && rules[i].port_low == it.lo;
            if (same_port && rules[i].target == it.tgt) begin
              a.verdict = rules[i].code;
              hit = 1'b1;
            end else if (same_port && rules[i].target == 0) cat[0] = rules[i].code;
            else if (rules[i].target == it.tgt) cat[1] = rules[i].code;
            else if (rules[i].port_low == 0) cat[2] = rules[i].code;
            else if (rules[i].target == 0) cat[3] = rules[i].code;
          end
        end
        if (!hit) begin
          a.verdict = allow_now;
          for (int k = 3; k >= 0; k--) if (cat[k] != 0) a.verdict = cat[k];
        end
      end
    endcase
    return a;
  endfunction

  // result check
  always @(posedge clk) begin
    answer_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        report("unexpected result", int'(out_verdict), 0);
      end else begin
        w = pending_answers.pop_front();
        if (out_verdict !== w.verdict) report("verdict", int'(out_verdict), int'(w.verdict));
        if (out_status !== w.status) report("status", int'(out_status), int'(w.status));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("port_access_rule_table verification failed");
      $finish;
    end
  end

  // send one item, optionally idling first; start stays high until the next
  // idle gap or drain
  task automatic send_item(input item_t it, input bit has_want, input answer_t want);
    answer_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= it.cmd;
    in_port_name_high <= it.hi;
    in_port_name_low <= it.lo;
    in_target_number <= it.tgt;
    in_rule_code <= it.code;
    in_every_target <= it.every;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = rule_table_apply(it);
    if (has_want && p.verdict != want.verdict)
      report("directed verdict", int'(p.verdict), int'(want.verdict));
    if (has_want && p.status != want.status)
      report("directed status", int'(p.status), int'(want.status));
    pending_answers.push_back(p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_allow(input logic [2:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_allow_code <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    allow_now = v;
  endtask

  // small port pool so matches happen often
  function automatic logic [63:0] pick_word();
    case ($urandom_range(4))
      0: return 64'd0;
      1: return '1;
      2: return 64'(1) << $urandom_range(63);
      default: return 64'($urandom_range(3));
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    r = $urandom_range(99);
    it.cmd = r < 40 ? CMD_ADD : r < 55 ? CMD_REMOVE : r < 60 ? CMD_CLEAR : CMD_CHECK;
    if ($urandom_range(9) == 0) begin
      it.hi = {$urandom, $urandom};
      it.lo = {$urandom, $urandom};
    end else begin
      it.hi = pick_word();
      it.lo = pick_word();
    end
    it.tgt = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(3));
    if ($urandom_range(19) == 0) it.tgt = 16'hFFFF;
    it.code = 3'($urandom);
    it.every = (it.cmd == CMD_CLEAR) ? ($urandom_range(3) == 0) : 1'($urandom);
    return it;
  endfunction

  typedef struct {
    item_t   it;
    bit      has_want;
    answer_t want;
  } row_t;

  localparam logic [63:0] Ones = '1;

  row_t directed[] = '{
    '{'{CMD_CHECK, 64'd5, 64'd6, 16'd7, 3'd0, 1'b0}, 1, '{3'd1, 1'b0}},
    '{'{CMD_ADD, Ones, Ones, 16'hFFFF, 3'd7, 1'b1}, 1, '{3'd0, 1'b0}},
    '{'{CMD_CHECK, Ones, Ones, 16'hFFFF, 3'd0, 1'b0}, 1, '{3'd7, 1'b0}},
    '{'{CMD_ADD, Ones, Ones, 16'hFFFF, 3'd0, 1'b0}, 1, '{3'd0, 1'b0}},
    '{'{CMD_CHECK, Ones, Ones, 16'hFFFF, 3'd5, 1'b1}, 1, '{3'd0, 1'b0}},
    '{'{CMD_ADD, 64'd0, 64'd0, 16'd0, 3'd3, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_ADD, 64'd9, 64'd0, 16'd4, 3'd2, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_ADD, 64'd9, 64'd8, 16'd0, 3'd6, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_ADD, 64'd1, 64'd1, 16'd4, 3'd5, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_CHECK, 64'd9, 64'd8, 16'd4, 3'd0, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_CHECK, 64'd2, 64'd2, 16'd4, 3'd0, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_CHECK, 64'd2, 64'd2, 16'd3, 3'd0, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_REMOVE, 64'd7, 64'd7, 16'd7, 3'd0, 1'b0}, 1, '{3'd0, 1'b0}},
    '{'{CMD_REMOVE, 64'd9, 64'd8, 16'd0, 3'd0, 1'b1}, 1, '{3'd0, 1'b0}},
    '{'{CMD_CLEAR, 64'd0, 64'd0, 16'd55, 3'd0, 1'b0}, 1, '{3'd0, 1'b0}},
    '{'{CMD_CLEAR, 64'd0, 64'd0, 16'd4, 3'd0, 1'b0}, 1, '{3'd0, 1'b0}},
    '{'{CMD_CHECK, 64'd2, 64'd2, 16'd4, 3'd0, 1'b0}, 0, '{3'd0, 1'b0}},
    '{'{CMD_CLEAR, Ones, Ones, 16'hFFFF, 3'd7, 1'b1}, 1, '{3'd0, 1'b0}},
    '{'{CMD_CHECK, Ones, Ones, 16'hFFFF, 3'd0, 1'b0}, 1, '{3'd1, 1'b0}}
  };

  initial begin
    item_t it;
    answer_t none;
    none = '{3'd0, 1'b0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].it, directed[i].has_want, directed[i].want);

    // fill to full, then add on full and update on full
    for (int i = 0; i < Slots; i++) begin
      it = '{CMD_ADD, 64'd100, 64'(i), 16'(i), 3'(i), 1'b0};
      send_item(it, 0, none);
    end
    it = '{CMD_ADD, 64'd200, 64'd1, 16'd1, 3'd1, 1'b0};
    send_item(it, 1, '{3'd0, 1'b1});
    it = '{CMD_ADD, 64'd100, 64'd3, 16'd3, 3'd7, 1'b0};
    send_item(it, 1, '{3'd0, 1'b0});
    it = '{CMD_CLEAR, 64'd0, 64'd0, 16'd0, 3'd0, 1'b1};
    send_item(it, 0, none);

    write_allow(3'd0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 36 : ph == 1 ? 83 : 0;
      for (int n = 0; n < 440; n++) begin
        send_item(random_item(), 0, none);
        if (n == 200) drain();
      end
      write_allow(ph == 0 ? 3'd7 : 3'($urandom));
    end

    drain();
    if (errors == 0) $display("port_access_rule_table verification clean");
    else $display("port_access_rule_table verification failed");
    $finish;
  end
endmodule
`default_nettype wire
